FILE: src/fct_pkg.sv
// shared constants and types for the frustum cull test core
// no dependencies
package fct_pkg;

   localparam int NumPlanes = 6;
   localparam int NumRegs   = 8;
   localparam int NumCoefs  = NumPlanes * 4;
   localparam int CsrIdxW   = 4;
   localparam int CsrDataW  = 64;

   // reset matrix: identity, low half first
   localparam logic [CsrDataW-1:0] MatrixReset [NumRegs] = '{
      64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
      64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
   };

   // planes left, right, bottom, top, near, far
   localparam logic [1:0] PlaneCol  [NumPlanes] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
   localparam logic       PlaneNeg  [NumPlanes] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
   localparam logic       PlaneUse4 [NumPlanes] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

   typedef logic [NumCoefs-1:0][31:0] coefs_type;

   typedef struct packed {
      logic        req_type;
      logic [31:0] center_x;
      logic [31:0] center_y;
      logic [31:0] center_z;
      logic [30:0] extent_x;
      logic [30:0] extent_y;
      logic [30:0] extent_z;
      logic [30:0] radius;
   } item_type;

   typedef struct packed {
      logic busy;
   } gen_status_type;

endpackage

FILE: src/frustum_cull_test_core.sv
// top level of the frustum cull test core: plane derivation and test pipeline
// uses fct_pkg, fct_plane_gen, fct_test_pipe
//
//  channel  handshake                    payload
//  req      req_valid / req_ready        req_type, req_center_*, req_extent_*, req_radius
//  rsp      rsp_valid / rsp_ready        rsp_inside_res
//  csr      csr_write_en                 csr_index, csr_wdata
//
// one word per cycle sustained while rsp is not stalled and no plane derivation runs
// after reset and after each register write the planes are derived again, per plane:
// a load, squares and their sum, bit-serial root steps and a bit-serial divide of each of four components,
// req_ready stays low meanwhile
// a stalled rsp freezes the whole pipeline; nothing is lost or repeated
module frustum_cull_test_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic signed [31:0]            req_center_x,
   input  logic signed [31:0]            req_center_y,
   input  logic signed [31:0]            req_center_z,
   input  logic [30:0]                   req_extent_x,
   input  logic [30:0]                   req_extent_y,
   input  logic [30:0]                   req_extent_z,
   input  logic [30:0]                   req_radius,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_inside_res,
   input  logic                          csr_write_en,
   input  logic [fct_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [fct_pkg::CsrDataW-1:0]  csr_wdata
);

   fct_pkg::coefs_type      coefs;
   fct_pkg::gen_status_type gen_status;
   fct_pkg::item_type       item;
   logic                    advance;

   assign item.req_type = req_type;
   assign item.center_x = req_center_x;
   assign item.center_y = req_center_y;
   assign item.center_z = req_center_z;
   assign item.extent_x = req_extent_x;
   assign item.extent_y = req_extent_y;
   assign item.extent_z = req_extent_z;
   assign item.radius   = req_radius;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance && !gen_status.busy;

   fct_plane_gen u_plane_gen (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .coefs        (coefs),
      .status       (gen_status)
   );

   fct_test_pipe u_test_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid && req_ready),
      .in_item    (item),
      .coefs      (coefs),
      .advance    (advance),
      .out_valid  (rsp_valid),
      .out_inside (rsp_inside_res)
   );

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      gen_status.busy |-> !req_ready)
      else $error("word accepted while planes are derived");
   a_accept_reaches_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 rsp_ready [*3] |=> rsp_valid)
      else $error("accepted word did not reach the output");
   a_cfg_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_write_en && (csr_index < fct_pkg::CsrIdxW'(fct_pkg::NumRegs)) |=> !req_ready)
      else $error("register write did not block input");
`endif

endmodule

FILE: src/fct_plane_gen.sv
// matrix registers and sequential plane derivation: square sum, bit-serial root,
// bit-serial divide per component; uses fct_pkg
module fct_plane_gen (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [fct_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [fct_pkg::CsrDataW-1:0]      csr_wdata,
   output fct_pkg::coefs_type                coefs,
   output fct_pkg::gen_status_type           status
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_SQ    = 3'd2;
   localparam logic [2:0] ST_ACC   = 3'd3;
   localparam logic [2:0] ST_ROOT  = 3'd4;
   localparam logic [2:0] ST_DINIT = 3'd5;
   localparam logic [2:0] ST_DIV   = 3'd6;
   localparam logic [2:0] ST_WRITE = 3'd7;

   localparam logic [5:0] RootSteps = 6'd34;
   localparam logic [5:0] DivSteps  = 6'd49;

   logic [fct_pkg::CsrDataW-1:0] matrix_ff [fct_pkg::NumRegs];
   logic [fct_pkg::CsrDataW-1:0] matrix_in [fct_pkg::NumRegs];
   logic [31:0]        coef_ff [fct_pkg::NumCoefs];
   logic [2:0]         state_ff, state_in;
   logic [2:0]         plane_ff, plane_in;
   logic [1:0]         comp_ff, comp_in;
   logic [5:0]         step_ff, step_in;
   logic signed [33:0] v_ff [4];
   logic signed [33:0] v_in [4];
   logic [65:0]        prod_ff, prod_in;
   logic [67:0]        sum_ff, sum_in;
   logic [67:0]        rad_ff, rad_in;
   logic [34:0]        rem_ff, rem_in;
   logic [33:0]        root_ff, root_in;
   logic [48:0]        num_ff, num_in;
   logic [33:0]        drem_ff, drem_in;
   logic [48:0]        quo_ff, quo_in;
   logic               wr_en;
   logic [4:0]         wr_idx;
   logic [31:0]        wr_val;

   logic signed [33:0] load_v [4];
   logic [32:0]        mag_cur;
   logic [36:0]        rem_t, trial;
   logic [34:0]        div_t;
   logic [31:0]        sat_val;
   logic               cfg_hit;
   logic               last_comp;

   always_comb begin
      logic [1:0]         col;
      logic [2:0]         ei, bi;
      logic [31:0]        e, b;
      logic signed [33:0] es, bs;
      col = fct_pkg::PlaneCol[plane_ff];
      for (int j = 0; j < 4; j++) begin
         ei = {2'(j), col[1]};
         bi = {2'(j), 1'b1};
         e  = col[0] ? matrix_ff[ei][63:32] : matrix_ff[ei][31:0];
         b  = matrix_ff[bi][63:32];
         es = 34'($signed(e));
         bs = fct_pkg::PlaneUse4[plane_ff] ? 34'($signed(b)) : 34'sd0;
         load_v[j] = fct_pkg::PlaneNeg[plane_ff] ? bs - es : bs + es;
      end
   end

   assign mag_cur   = v_ff[comp_ff][33] ? 33'(-v_ff[comp_ff]) : v_ff[comp_ff][32:0];
   assign rem_t     = {rem_ff, rad_ff[67:66]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign div_t     = {drem_ff, num_ff[48]};
   assign cfg_hit   = csr_write_en && (csr_index < fct_pkg::CsrIdxW'(fct_pkg::NumRegs));
   assign last_comp = (comp_ff == 2'd3);

   always_comb begin
      if (v_ff[comp_ff][33]) begin
         sat_val = (quo_ff > 49'h0_8000_0000) ? 32'h8000_0000 : (~quo_ff[31:0] + 32'd1);
      end else begin
         sat_val = (quo_ff > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : quo_ff[31:0];
      end
   end

   always_comb begin
      matrix_in = matrix_ff;
      state_in  = state_ff;
      plane_in  = plane_ff;
      comp_in   = comp_ff;
      step_in   = step_ff;
      v_in      = v_ff;
      prod_in   = prod_ff;
      sum_in    = sum_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      num_in    = num_ff;
      drem_in   = drem_ff;
      quo_in    = quo_ff;
      wr_en     = 1'b0;
      wr_idx    = {plane_ff[2:0], comp_ff};
      wr_val    = sat_val;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_LOAD: begin
            v_in     = load_v;
            sum_in   = '0;
            comp_in  = 2'd0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            prod_in  = 66'(mag_cur) * 66'(mag_cur);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sum_in = sum_ff + 68'(prod_ff);
            if (comp_ff == 2'd2) begin
               rad_in   = sum_ff + 68'(prod_ff);
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = ST_ROOT;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = ST_SQ;
            end
         end
         ST_ROOT: begin
            rad_in  = {rad_ff[65:0], 2'b00};
            step_in = step_ff + 6'd1;
            if (rem_t >= trial) begin
               rem_in  = 35'(rem_t - trial);
               root_in = {root_ff[32:0], 1'b1};
            end else begin
               rem_in  = rem_t[34:0];
               root_in = {root_ff[32:0], 1'b0};
            end
            if (step_ff == RootSteps - 6'd1) begin
               comp_in  = 2'd0;
               state_in = ST_DINIT;
            end
         end
         ST_DINIT: begin
            if (root_ff == '0) begin
               wr_en  = 1'b1;
               wr_val = '0;
               if (last_comp) begin
                  plane_in = plane_ff + 3'd1;
                  state_in = (plane_ff == 3'(fct_pkg::NumPlanes - 1)) ? ST_IDLE : ST_LOAD;
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end else begin
               num_in   = {mag_cur, 16'h0000};
               drem_in  = '0;
               quo_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            num_in  = {num_ff[47:0], 1'b0};
            step_in = step_ff + 6'd1;
            if (div_t >= {1'b0, root_ff}) begin
               drem_in = 34'(div_t - {1'b0, root_ff});
               quo_in  = {quo_ff[47:0], 1'b1};
            end else begin
               drem_in = div_t[33:0];
               quo_in  = {quo_ff[47:0], 1'b0};
            end
            if (step_ff == DivSteps - 6'd1) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wr_en = 1'b1;
            if (last_comp) begin
               plane_in = plane_ff + 3'd1;
               state_in = (plane_ff == 3'(fct_pkg::NumPlanes - 1)) ? ST_IDLE : ST_LOAD;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = ST_DINIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cfg_hit) begin
         matrix_in[csr_index[2:0]] = csr_wdata;
         state_in = ST_LOAD;
         plane_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= fct_pkg::MatrixReset;
         state_ff  <= ST_LOAD;
         plane_ff  <= '0;
         comp_ff   <= '0;
         step_ff   <= '0;
      end else begin
         matrix_ff <= matrix_in;
         state_ff  <= state_in;
         plane_ff  <= plane_in;
         comp_ff   <= comp_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      num_ff  <= num_in;
      drem_ff <= drem_in;
      quo_ff  <= quo_in;
      if (wr_en) begin
         coef_ff[wr_idx] <= wr_val;
      end
   end

   always_comb begin
      for (int i = 0; i < fct_pkg::NumCoefs; i++) begin
         coefs[i] = coef_ff[i];
      end
   end

   assign status.busy = (state_ff != ST_IDLE);

`ifndef SYNTHESIS
   a_cfg_restarts: assert property (@(posedge clock) disable iff (reset)
      cfg_hit |=> (state_ff == ST_LOAD) && (plane_ff == '0))
      else $error("register write did not restart plane derivation");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (root_ff != '0))
      else $error("divide started with zero plane length");
   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (step_ff < RootSteps))
      else $error("root step count out of range");
   a_plane_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (plane_ff < 3'(fct_pkg::NumPlanes)))
      else $error("plane index out of range while busy");
`endif

endmodule

FILE: src/fct_test_pipe.sv
// four-stage box / sphere test against six planes with stall by global enable
// uses fct_pkg
module fct_test_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  fct_pkg::item_type     in_item,
   input  fct_pkg::coefs_type    coefs,
   input  logic                  advance,
   output logic                  out_valid,
   output logic                  out_inside
);

   localparam int NP = fct_pkg::NumPlanes;

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic               v1_in, v2_in, v3_in, v4_in;
   logic signed [32:0] pt_ff   [NP][3];
   logic signed [32:0] pt_in   [NP][3];
   logic [46:0]        thr1_ff, thr1_in, thr2_ff, thr2_in, thr3_ff, thr3_in;
   logic signed [64:0] prod_ff [NP][3];
   logic signed [64:0] prod_in [NP][3];
   logic signed [65:0] pa_ff [NP];
   logic signed [65:0] pa_in [NP];
   logic signed [65:0] pb_ff [NP];
   logic signed [65:0] pb_in [NP];
   logic               inside_ff, inside_in;

   always_comb begin
      logic signed [32:0] c [3];
      logic signed [32:0] e [3];
      c[0] = 33'($signed(in_item.center_x));
      c[1] = 33'($signed(in_item.center_y));
      c[2] = 33'($signed(in_item.center_z));
      e[0] = {2'b00, in_item.extent_x};
      e[1] = {2'b00, in_item.extent_y};
      e[2] = {2'b00, in_item.extent_z};
      for (int k = 0; k < NP; k++) begin
         for (int j = 0; j < 3; j++) begin
            if (in_item.req_type) begin
               pt_in[k][j] = c[j];
            end else if (coefs[k*4+j][31]) begin
               pt_in[k][j] = c[j] - e[j];
            end else begin
               pt_in[k][j] = c[j] + e[j];
            end
         end
      end
      thr1_in = in_item.req_type ? {in_item.radius, 16'h0000} : '0;
      v1_in   = in_valid;
   end

   always_comb begin
      for (int k = 0; k < NP; k++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[k][j] = 65'($signed(coefs[k*4+j])) * 65'(pt_ff[k][j]);
         end
      end
      thr2_in = thr1_ff;
      v2_in   = v1_ff;
   end

   always_comb begin
      logic signed [65:0] w;
      for (int k = 0; k < NP; k++) begin
         w = $signed({{18{coefs[k*4+3][31]}}, coefs[k*4+3], 16'h0000});
         pa_in[k] = 66'(prod_ff[k][0]) + 66'(prod_ff[k][1]);
         pb_in[k] = 66'(prod_ff[k][2]) + w;
      end
      thr3_in = thr2_ff;
      v3_in   = v2_ff;
   end

   always_comb begin
      logic signed [67:0] s;
      inside_in = 1'b1;
      for (int k = 0; k < NP; k++) begin
         s = 68'(pa_ff[k]) + 68'(pb_ff[k]) + $signed({21'h0, thr3_ff});
         if (s[67]) begin
            inside_in = 1'b0;
         end
      end
      v4_in = v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pt_ff     <= pt_in;
         thr1_ff   <= thr1_in;
         prod_ff   <= prod_in;
         thr2_ff   <= thr2_in;
         pa_ff     <= pa_in;
         pb_ff     <= pb_in;
         thr3_ff   <= thr3_in;
         inside_ff <= inside_in;
      end
   end

   assign out_valid  = v4_ff;
   assign out_inside = inside_ff;

`ifndef SYNTHESIS
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !advance |=> v4_ff && $stable(inside_ff))
      else $error("result word changed during stall");
   a_valid_travels: assert property (@(posedge clock) disable iff (reset)
      advance && v2_ff |=> v3_ff)
      else $error("valid lost between stages");
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(v1_ff) && $stable(v2_ff) && $stable(v3_ff))
      else $error("pipeline moved during stall");
`endif

endmodule
